// ----- rtl/dtsw_pkg.sv -----
`timescale 1ns / 1ps

package dtsw_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_LEVEL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_MIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_MAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_TAG        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_CHANNEL  = 3'd5;

  localparam logic [8:0]  HOLD_TICKS_END = 9'd300;
  localparam logic [8:0]  HOLD_MAX       = 9'h1FF;
  localparam logic [15:0] STEADY_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [15:0] debounce_delay;
    logic        rest_level;
    logic [11:0] servo_min;
    logic [11:0] servo_max;
    logic [7:0]  hit_tag;
    logic [3:0]  servo_channel;
  } cfg_t;

  typedef struct packed {
    logic        last_raw;
    logic        stable_level;
    logic [15:0] steady_ticks;
    logic        hit_armed_off;
    logic        resetting;
    logic        push_phase;
    logic [8:0]  hold_ticks;
  } state_t;

  typedef struct packed {
    logic        hit_valid;
    logic [7:0]  hit_component;
    logic        servo_write;
    logic [3:0]  servo_chan_out;
    logic [11:0] servo_position;
    logic        switch_active;
  } result_t;

  localparam cfg_t CFG_RESET = '{
    debounce_delay: 16'd10,
    rest_level:     1'b1,
    servo_min:      12'd0,
    servo_max:      12'd4095,
    hit_tag:        8'd0,
    servo_channel:  4'd0
  };

  localparam state_t STATE_RESET = '{
    last_raw:      1'b1,
    stable_level:  1'b1,
    steady_ticks:  16'd0,
    hit_armed_off: 1'b0,
    resetting:     1'b0,
    push_phase:    1'b0,
    hold_ticks:    9'd0
  };

endpackage

// ----- rtl/dtsw_step.sv -----
`timescale 1ns / 1ps

module dtsw_step (
  input  dtsw_pkg::cfg_t    cfg,
  input  dtsw_pkg::state_t  state,
  input  logic              pin_level,
  input  logic              reset_request,
  output dtsw_pkg::state_t  state_nxt,
  output dtsw_pkg::result_t result
);
  import dtsw_pkg::*;

  logic        raw_chg;
  logic [15:0] steady_base;
  logic        active;
  logic        seq_run;
  logic [8:0]  hold_inc;

  assign raw_chg     = pin_level != state.last_raw;
  assign steady_base = raw_chg ? 16'd0 : state.steady_ticks;
  assign seq_run     = state.resetting | reset_request;
  assign hold_inc    = (state.hold_ticks < HOLD_MAX) ? state.hold_ticks + 9'd1
                                                     : state.hold_ticks;

  always_comb begin
    state_nxt = state;
    result    = '0;

    // debounce
    state_nxt.last_raw = pin_level;
    if ((state.stable_level != pin_level) && (steady_base >= cfg.debounce_delay)) begin
      state_nxt.stable_level = pin_level;
    end
    state_nxt.steady_ticks = (steady_base != STEADY_MAX) ? steady_base + 16'd1
                                                         : steady_base;

    active = state_nxt.stable_level ^ cfg.rest_level;
    result.switch_active = active;

    // fire once per activation, re-arm when inactive
    if (active) begin
      if (!state.hit_armed_off) begin
        state_nxt.hit_armed_off = 1'b1;
        result.hit_valid        = 1'b1;
        result.hit_component    = cfg.hit_tag;
      end
    end else begin
      state_nxt.hit_armed_off = 1'b0;
    end

    // servo push, hold, release
    state_nxt.resetting = seq_run;
    if (seq_run) begin
      if (!state.push_phase) begin
        result.servo_write     = 1'b1;
        result.servo_chan_out  = cfg.servo_channel;
        result.servo_position  = cfg.servo_max;
        state_nxt.push_phase   = 1'b1;
        state_nxt.hold_ticks   = 9'd0;
      end else begin
        state_nxt.hold_ticks = hold_inc;
        if (hold_inc >= HOLD_TICKS_END) begin
          result.servo_write    = 1'b1;
          result.servo_chan_out = cfg.servo_channel;
          result.servo_position = cfg.servo_min;
          state_nxt.push_phase  = 1'b0;
          state_nxt.hold_ticks  = 9'd0;
          state_nxt.resetting   = 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/debounced_target_switch_with_servo_reset.sv -----
`timescale 1ns / 1ps

// Debounced target switch with hit event and servo reset sequence. Each input
// request is one 1 ms tick carrying the raw switch level and a reset request;
// each produces exactly one result with the hit message, any servo command and
// the debounced active state. The block takes one request per clock cycle while
// the output side is free; the input register loads at acceptance, the result
// register when the request advances, and the whole per-tick update
// is a single short combinational step between them. out_ready low stalls the
// result register, and the input side keeps accepting while the result register
// can still be freed. Configuration writes are always accepted (cfg_ready is
// tied high) and must only be made while no request is in flight. No clearing
// pass follows reset.
module debounced_target_switch_with_servo_reset (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_pin_level,
  input  logic                                in_reset_request,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit_valid,
  output logic [7:0]                          out_hit_component,
  output logic                                out_servo_write,
  output logic [3:0]                          out_servo_chan_out,
  output logic [11:0]                         out_servo_position,
  output logic                                out_switch_active,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dtsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtsw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dtsw_pkg::*;

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;

  logic in_vld_r;
  logic pin_r;
  logic req_r;
  logic out_vld_r;
  logic advance;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE_DELAY: cfg_r.debounce_delay <= cfg_data[15:0];
        REG_REST_LEVEL:     cfg_r.rest_level     <= cfg_data[0];
        REG_SERVO_MIN:      cfg_r.servo_min      <= cfg_data[11:0];
        REG_SERVO_MAX:      cfg_r.servo_max      <= cfg_data[11:0];
        REG_HIT_TAG:        cfg_r.hit_tag        <= cfg_data[7:0];
        REG_SERVO_CHANNEL:  cfg_r.servo_channel  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  dtsw_step u_step (
    .cfg           (cfg_r),
    .state         (state_r),
    .pin_level     (pin_r),
    .reset_request (req_r),
    .state_nxt     (state_nxt),
    .result        (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pin_r <= in_pin_level;
      req_r <= in_reset_request;
    end
  end

  // tick state and result register advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= STATE_RESET;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r   <= state_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_hit_valid      = res_r.hit_valid;
  assign out_hit_component  = res_r.hit_component;
  assign out_servo_write    = res_r.servo_write;
  assign out_servo_chan_out = res_r.servo_chan_out;
  assign out_servo_position = res_r.servo_position;
  assign out_switch_active  = res_r.switch_active;

`ifndef SYNTHESIS
  a_hit_implies_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.hit_valid) |-> res_r.switch_active)
    else $error("hit emitted while switch inactive");

  a_hold_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.hold_ticks < HOLD_TICKS_END)
    else $error("hold counter passed its end");

  a_hold_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.push_phase |-> (state_r.hold_ticks == 9'd0))
    else $error("hold counter running outside push phase");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ready)
    else $error("input stage empty but not ready");
`endif

endmodule
